/* rtl/smeu_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack machine execute unit package
// Shared payload types, primitive codes and status codes.
// ----------------------------------------------------------------------------
package smeu_pkg;

   localparam int StackDepthDefault = 32;
   localparam int MemWordsDefault   = 256;

   localparam logic [5:0] OP_LIT   = 6'd0;
   localparam logic [5:0] OP_BR    = 6'd1;
   localparam logic [5:0] OP_ZBR   = 6'd2;
   localparam logic [5:0] OP_DROP  = 6'd3;
   localparam logic [5:0] OP_SWAP  = 6'd4;
   localparam logic [5:0] OP_DUP   = 6'd5;
   localparam logic [5:0] OP_OVER  = 6'd6;
   localparam logic [5:0] OP_ROT   = 6'd7;
   localparam logic [5:0] OP_NROT  = 6'd8;
   localparam logic [5:0] OP_ADD   = 6'd9;
   localparam logic [5:0] OP_SUB   = 6'd10;
   localparam logic [5:0] OP_MUL   = 6'd11;
   localparam logic [5:0] OP_DIV   = 6'd12;
   localparam logic [5:0] OP_MOD   = 6'd13;
   localparam logic [5:0] OP_EQ    = 6'd14;
   localparam logic [5:0] OP_NE    = 6'd15;
   localparam logic [5:0] OP_LT    = 6'd16;
   localparam logic [5:0] OP_GT    = 6'd17;
   localparam logic [5:0] OP_LE    = 6'd18;
   localparam logic [5:0] OP_GE    = 6'd19;
   localparam logic [5:0] OP_LAND  = 6'd20;
   localparam logic [5:0] OP_LOR   = 6'd21;
   localparam logic [5:0] OP_LNOT  = 6'd22;
   localparam logic [5:0] OP_BAND  = 6'd23;
   localparam logic [5:0] OP_BOR   = 6'd24;
   localparam logic [5:0] OP_BXOR  = 6'd25;
   localparam logic [5:0] OP_BNOT  = 6'd26;
   localparam logic [5:0] OP_STORE = 6'd27;
   localparam logic [5:0] OP_FETCH = 6'd28;
   localparam logic [5:0] OP_ADDST = 6'd29;
   localparam logic [5:0] OP_SUBST = 6'd30;
   localparam logic [5:0] OP_CSTORE = 6'd31;
   localparam logic [5:0] OP_CFETCH = 6'd32;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_UNDER = 2'd1;
   localparam logic [1:0] ST_OVER  = 2'd2;
   localparam logic [1:0] ST_DIVZ  = 2'd3;

   typedef struct packed {
      logic [5:0]         action;
      logic signed [63:0] operand;
   } req_type;

   typedef struct packed {
      logic signed [63:0] top_value;
      logic [5:0]         depth_now;
      logic               branch_taken;
      logic [1:0]         status;
   } rsp_type;

   // Operands needed by each primitive.
   function automatic logic [1:0] op_need(input logic [5:0] op);
      logic [1:0] n;
      n = 2'd2;
      case (op)
         OP_LIT, OP_BR: n = 2'd0;
         OP_ZBR, OP_DROP, OP_DUP, OP_LNOT, OP_BNOT, OP_FETCH, OP_CFETCH: n = 2'd1;
         OP_ROT, OP_NROT: n = 2'd3;
         default: n = 2'd2;
      endcase
      return n;
   endfunction

   // Start and result of a signed division.
   typedef struct packed {
      logic        start;
      logic        rem;
      logic [63:0] dividend;
      logic [63:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] result;
   } div_rsp_type;

endpackage

/* rtl/smeu_divider.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack machine divider
// Radix-2 restoring signed divider, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module smeu_divider
   import smeu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic        busy_ff, busy_in;
   logic [6:0]  count_ff, count_in;
   logic [63:0] quo_ff, quo_in;
   logic [63:0] rem_ff, rem_in;
   logic [63:0] den_ff, den_in;
   logic        neg_q_ff, neg_q_in;
   logic        neg_r_ff, neg_r_in;
   logic        sel_rem_ff, sel_rem_in;
   logic        done_ff, done_in;
   logic [63:0] res_ff, res_in;
   logic [64:0] trial;
   logic [63:0] shifted;

   always_comb begin
      busy_in = busy_ff; count_in = count_ff; quo_in = quo_ff; rem_in = rem_ff;
      den_in = den_ff; neg_q_in = neg_q_ff; neg_r_in = neg_r_ff;
      sel_rem_in = sel_rem_ff; done_in = 1'b0; res_in = res_ff;
      shifted = {rem_ff[62:0], quo_ff[63]};
      trial = {1'b0, shifted} - {1'b0, den_ff};
      if (div_req.start) begin
         busy_in    = 1'b1;
         count_in   = 7'd64;
         quo_in     = div_req.dividend[63] ? (64'd0 - div_req.dividend) : div_req.dividend;
         den_in     = div_req.divisor[63] ? (64'd0 - div_req.divisor) : div_req.divisor;
         rem_in     = 64'd0;
         neg_r_in   = div_req.dividend[63];
         neg_q_in   = div_req.dividend[63] ^ div_req.divisor[63];
         sel_rem_in = div_req.rem;
      end else if (busy_ff) begin
         if (count_ff == 7'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (sel_rem_ff) begin
               res_in = neg_r_ff ? (64'd0 - rem_ff) : rem_ff;
            end else begin
               res_in = neg_q_ff ? (64'd0 - quo_ff) : quo_ff;
            end
         end else begin
            count_in = count_ff - 7'd1;
            if (!trial[64]) begin
               rem_in = trial[63:0];
               quo_in = {quo_ff[62:0], 1'b1};
            end else begin
               rem_in = shifted;
               quo_in = {quo_ff[62:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in; quo_ff <= quo_in; rem_ff <= rem_in; den_ff <= den_in;
      neg_q_ff <= neg_q_in; neg_r_ff <= neg_r_in; sel_rem_ff <= sel_rem_in;
      res_ff <= res_in;
   end

   assign div_rsp.done   = done_ff;
   assign div_rsp.result = res_ff;

endmodule

/* rtl/stack_machine_execute_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack machine execute unit
// Runs one Forth-style primitive per beat on a memory-held data stack.
// ----------------------------------------------------------------------------
// Each primitive reads the three top stack entries and the addressed data word,
// executes, then writes back before the response is registered; divide and
// modulo also wait on the serial divider.
// One primitive in flight at a time: a new request is taken only while idle.
// Reset: clears the depth at once, then clears the data memory one word a
// cycle until all MEM_WORDS words are zero, during which no request is accepted.
module stack_machine_execute_unit
   import smeu_pkg::*;
#(
   parameter int STACK_DEPTH = StackDepthDefault,
   parameter int MEM_WORDS   = MemWordsDefault
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int SpW = $clog2(STACK_DEPTH);
   localparam int DpW = $clog2(STACK_DEPTH + 1);
   localparam int MaW = $clog2(MEM_WORDS);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_READ  = 3'd2;
   localparam logic [2:0] S_EXEC  = 3'd3;
   localparam logic [2:0] S_DIV   = 3'd4;
   localparam logic [2:0] S_WB    = 3'd5;
   localparam logic [2:0] S_OUT   = 3'd6;

   logic [63:0] stack_mem [STACK_DEPTH];
   logic [63:0] data_mem  [MEM_WORDS];

   logic [2:0]     state_ff, state_in;
   logic [DpW-1:0] depth_ff, depth_in;
   logic [MaW:0]   clr_ff, clr_in;
   logic [5:0]     op_ff;
   logic [63:0]    lit_ff;
   logic [63:0]    t_ff, s_ff, u_ff, m_ff;
   logic [63:0]    t_rd, s_rd, u_rd, m_rd;
   logic [63:0]    w0_ff, w1_ff, w2_ff, mw_ff;
   logic [63:0]    w0_in, w1_in, w2_in, mw_in;
   logic [2:0]     wen_ff, wen_in;
   logic           mwen_ff, mwen_in;
   logic [DpW-1:0] ndepth_ff, ndepth_in;
   logic           taken_ff, taken_in;
   logic [1:0]     status_ff, status_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_ff, rsp_in;
   logic [MaW-1:0] maddr;
   logic [63:0]    pll_ff;
   logic [31:0]    plh_ff, phl_ff;
   div_req_type    div_req;
   div_rsp_type    div_rsp;
   logic [63:0]    new_top;
   logic [63:0]    top_ff;

   // Stack slot of the k-th entry from the top (k = 1 is the top itself).
   function automatic logic [SpW-1:0] slot(input logic [DpW-1:0] d, input int k);
      logic [DpW-1:0] a;
      a = d - DpW'(k);
      return a[SpW-1:0];
   endfunction

   assign maddr = t_rd[MaW+2:3];

   // Reads: three stack entries in the same cycle through registered ports.
   always_ff @(posedge clock) begin
      t_rd <= stack_mem[slot(depth_ff, 1)];
      s_rd <= stack_mem[slot(depth_ff, 2)];
      u_rd <= stack_mem[slot(depth_ff, 3)];
   end

   always_ff @(posedge clock) begin
      m_rd <= data_mem[maddr];
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_WB) begin
         if (wen_ff[0]) stack_mem[slot(ndepth_ff, 1)] <= w0_ff;
         if (wen_ff[1]) stack_mem[slot(ndepth_ff, 2)] <= w1_ff;
         if (wen_ff[2]) stack_mem[slot(ndepth_ff, 3)] <= w2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_CLEAR) begin
         data_mem[clr_ff[MaW-1:0]] <= 64'd0;
      end else if (state_ff == S_WB && mwen_ff) begin
         data_mem[t_ff[MaW+2:3]] <= mw_ff;
      end
   end

   assign div_req.start    = (state_ff == S_EXEC) && (op_ff == OP_DIV || op_ff == OP_MOD)
                             && (status_in == ST_OK);
   assign div_req.rem      = (op_ff == OP_MOD);
   assign div_req.dividend = s_ff;
   assign div_req.divisor  = t_ff;

   smeu_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Only the low 64 bits of the product are kept, so the high-by-high
   // partial product is never needed and the cross terms keep 32 bits.
   always_ff @(posedge clock) begin
      pll_ff <= 64'(s_rd[31:0]) * 64'(t_rd[31:0]);
      plh_ff <= s_rd[31:0] * t_rd[63:32];
      phl_ff <= s_rd[63:32] * t_rd[31:0];
   end

   always_comb begin
      logic [63:0] r;
      logic [1:0]  need;
      logic        bin;
      logic [63:0] b;
      logic [63:0] mask;
      logic [5:0]  sh;
      need = op_need(op_ff);
      bin  = (op_ff >= OP_ADD) && (op_ff <= OP_BXOR) && (op_ff != OP_LNOT);
      sh   = {t_ff[2:0], 3'd0};
      mask = ~(64'hFF << sh);
      b    = (m_ff >> sh) & 64'hFF;
      r    = 64'd0;
      status_in = ST_OK; taken_in = 1'b0; ndepth_in = depth_ff;
      w0_in = t_ff; w1_in = s_ff; w2_in = u_ff; wen_in = 3'b000;
      mwen_in = 1'b0; mw_in = m_ff;
      if (op_ff > OP_CFETCH) begin
         status_in = ST_OK;
      end else if (depth_ff < DpW'(need)) begin
         status_in = ST_UNDER;
      end else if ((op_ff == OP_LIT || op_ff == OP_DUP || op_ff == OP_OVER)
                   && depth_ff == DpW'(STACK_DEPTH)) begin
         status_in = ST_OVER;
      end else if ((op_ff == OP_DIV || op_ff == OP_MOD) && t_ff == 64'd0) begin
         status_in = ST_DIVZ;
      end else begin
         case (op_ff)
            OP_ADD:  r = s_ff + t_ff;
            OP_SUB:  r = s_ff - t_ff;
            OP_MUL:  r = pll_ff + {plh_ff + phl_ff, 32'd0};
            OP_EQ:   r = {63'd0, s_ff == t_ff};
            OP_NE:   r = {63'd0, s_ff != t_ff};
            OP_LT:   r = {63'd0, $signed(s_ff) < $signed(t_ff)};
            OP_GT:   r = {63'd0, $signed(s_ff) > $signed(t_ff)};
            OP_LE:   r = {63'd0, $signed(s_ff) <= $signed(t_ff)};
            OP_GE:   r = {63'd0, $signed(s_ff) >= $signed(t_ff)};
            OP_LAND: r = {63'd0, (s_ff != 64'd0) && (t_ff != 64'd0)};
            OP_LOR:  r = {63'd0, (s_ff != 64'd0) || (t_ff != 64'd0)};
            OP_BAND: r = s_ff & t_ff;
            OP_BOR:  r = s_ff | t_ff;
            OP_BXOR: r = s_ff ^ t_ff;
            default: r = 64'd0;
         endcase
         if (bin) begin
            ndepth_in = depth_ff - DpW'(1);
            w0_in = r; wen_in = 3'b001;
         end
         case (op_ff)
            OP_LIT: begin
               ndepth_in = depth_ff + DpW'(1); w0_in = lit_ff; wen_in = 3'b001;
            end
            OP_BR: taken_in = 1'b1;
            OP_ZBR: begin
               taken_in = (t_ff == 64'd0); ndepth_in = depth_ff - DpW'(1);
            end
            OP_DROP: ndepth_in = depth_ff - DpW'(1);
            OP_SWAP: begin
               w0_in = s_ff; w1_in = t_ff; wen_in = 3'b011;
            end
            OP_DUP: begin
               ndepth_in = depth_ff + DpW'(1); w0_in = t_ff; wen_in = 3'b001;
            end
            OP_OVER: begin
               ndepth_in = depth_ff + DpW'(1); w0_in = s_ff; wen_in = 3'b001;
            end
            OP_ROT: begin
               w2_in = s_ff; w1_in = t_ff; w0_in = u_ff; wen_in = 3'b111;
            end
            OP_NROT: begin
               w2_in = t_ff; w1_in = u_ff; w0_in = s_ff; wen_in = 3'b111;
            end
            OP_LNOT: begin
               w0_in = {63'd0, t_ff == 64'd0}; wen_in = 3'b001;
            end
            OP_BNOT: begin
               w0_in = ~t_ff; wen_in = 3'b001;
            end
            OP_STORE: begin
               ndepth_in = depth_ff - DpW'(2); mwen_in = 1'b1; mw_in = s_ff;
            end
            OP_ADDST: begin
               ndepth_in = depth_ff - DpW'(2); mwen_in = 1'b1; mw_in = m_ff + s_ff;
            end
            OP_SUBST: begin
               ndepth_in = depth_ff - DpW'(2); mwen_in = 1'b1; mw_in = m_ff - s_ff;
            end
            OP_CSTORE: begin
               ndepth_in = depth_ff - DpW'(2); mwen_in = 1'b1;
               mw_in = (m_ff & mask) | ((s_ff & 64'hFF) << sh);
            end
            OP_FETCH: begin
               w0_in = m_ff; wen_in = 3'b001;
            end
            OP_CFETCH: begin
               w0_in = {{56{b[7]}}, b[7:0]}; wen_in = 3'b001;
            end
            default: ;
         endcase
      end
   end

   // Top after write-back: a freshly written top wins, otherwise the old
   // entries at their new place. It is taken during write-back, while the
   // depth register still holds the depth before the step.
   always_comb begin
      logic [DpW-1:0] drop;
      drop = depth_ff - ndepth_ff;
      if (ndepth_ff == '0) begin
         new_top = 64'd0;
      end else if (wen_ff[0]) begin
         new_top = w0_ff;
      end else if (drop == DpW'(1)) begin
         new_top = s_ff;
      end else if (drop == DpW'(2)) begin
         new_top = u_ff;
      end else begin
         new_top = t_ff;
      end
   end

   always_comb begin
      state_in = state_ff; depth_in = depth_ff; clr_in = clr_ff;
      rsp_valid_in = rsp_valid_ff; rsp_in = rsp_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + (MaW+1)'(1);
            if (clr_ff == (MaW+1)'(MEM_WORDS - 1)) state_in = S_IDLE;
         end
         S_IDLE: if (req_valid) state_in = S_READ;
         S_READ: state_in = S_EXEC;
         S_EXEC: state_in = div_req.start ? S_DIV : S_WB;
         S_DIV:  state_in = div_rsp.done ? S_WB : S_DIV;
         S_WB: begin
            state_in = S_OUT;
            depth_in = ndepth_ff;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_in.top_value    = top_ff;
               rsp_in.depth_now    = 6'(ndepth_ff);
               rsp_in.branch_taken = taken_ff;
               rsp_in.status       = status_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign req_ready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         depth_ff     <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
      if (req_valid && req_ready) begin
         op_ff  <= req_data.action;
         lit_ff <= req_data.operand;
      end
      if (state_ff == S_READ) begin
         t_ff <= t_rd; s_ff <= s_rd; u_ff <= u_rd; m_ff <= m_rd;
      end
      if (state_ff == S_EXEC) begin
         w0_ff <= w0_in; w1_ff <= w1_in; w2_ff <= w2_in; wen_ff <= wen_in;
         mw_ff <= mw_in; mwen_ff <= mwen_in; ndepth_ff <= ndepth_in;
         taken_ff <= taken_in; status_ff <= status_in;
      end
      if (state_ff == S_DIV && div_rsp.done) begin
         w0_ff <= div_rsp.result;
      end
      if (state_ff == S_WB) begin
         top_ff <= new_top;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_depth_range: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DpW'(STACK_DEPTH))
      else $error("stack depth beyond capacity");
   a_err_keeps_depth: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WB && status_ff != ST_OK) |-> ndepth_ff == depth_ff)
      else $error("error step changed depth");
   a_err_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WB && status_ff != ST_OK) |-> (wen_ff == 3'b000 && !mwen_ff))
      else $error("error step wrote state");
   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> !req_ready)
      else $error("request taken during clear");

endmodule

/* dv/stack_machine_execute_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack machine execute unit testbench
// Drives primitives through the request channel with random gaps and checks
// every response beat against a behavioural model of the stack and memory.
// ----------------------------------------------------------------------------
module stack_machine_execute_unit_test;
   import smeu_pkg::*;

   localparam int Depth     = 32;
   localparam int Words     = 256;
   localparam int IdleLimit = 20000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   logic [63:0] stack_mem [Depth];
   int unsigned stack_sp;
   logic [63:0] data_mem [Words];
   rsp_type     expected_rsp_q [$];
   int          error_count = 0;
   int          idle_cycles = 0;
   bit          hold_off = 1'b0;
   bit          stim_done = 1'b0;

   stack_machine_execute_unit u_dut (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   always #1 clock = ~clock;

   function automatic logic [1:0] operands_needed(input logic [5:0] op);
      case (op)
         OP_LIT, OP_BR: return 2'd0;
         OP_ZBR, OP_DROP, OP_DUP, OP_LNOT, OP_BNOT, OP_FETCH, OP_CFETCH: return 2'd1;
         OP_ROT, OP_NROT: return 2'd3;
         default: return 2'd2;
      endcase
   endfunction

   // Signed division truncating toward zero; the remainder follows the dividend.
   function automatic logic [63:0] signed_divide(input logic [63:0] a, input logic [63:0] b,
                                                 input bit rem);
      logic [63:0] ua, ub, r;
      ua = a[63] ? -a : a;
      ub = b[63] ? -b : b;
      if (rem) begin
         r = ua % ub;
         return a[63] ? -r : r;
      end
      r = ua / ub;
      return (a[63] != b[63]) ? -r : r;
   endfunction

   // Applies one primitive to the model state and queues the response it gives.
   function automatic void execute_primitive(input req_type rq);
      logic [5:0]  op;
      logic [63:0] t, s, u, r, b;
      logic [7:0]  wi;
      int          sh;
      bit          taken, binary;
      logic [1:0]  st;
      rsp_type     rs;
      op = rq.action;
      taken = 1'b0;
      st = ST_OK;
      r = '0;
      if (op <= OP_CFETCH) begin
         if (stack_sp < operands_needed(op)) st = ST_UNDER;
         else if ((op == OP_LIT || op == OP_DUP || op == OP_OVER) && stack_sp >= Depth)
            st = ST_OVER;
         else if ((op == OP_DIV || op == OP_MOD) && stack_mem[stack_sp-1] == 0) st = ST_DIVZ;
         else begin
            t = stack_sp >= 1 ? stack_mem[stack_sp-1] : '0;
            s = stack_sp >= 2 ? stack_mem[stack_sp-2] : '0;
            u = stack_sp >= 3 ? stack_mem[stack_sp-3] : '0;
            wi = t[10:3];
            sh = t[2:0] * 8;
            binary = (op >= OP_ADD && op <= OP_BXOR && op != OP_LNOT);
            case (op)
               OP_LIT: begin stack_mem[stack_sp] = rq.operand; stack_sp++; end
               OP_BR: taken = 1'b1;
               OP_ZBR: begin taken = (t == 0); stack_sp--; end
               OP_DROP: stack_sp--;
               OP_SWAP: begin stack_mem[stack_sp-1] = s; stack_mem[stack_sp-2] = t; end
               OP_DUP: begin stack_mem[stack_sp] = t; stack_sp++; end
               OP_OVER: begin stack_mem[stack_sp] = s; stack_sp++; end
               OP_ROT: begin
                  stack_mem[stack_sp-3] = s; stack_mem[stack_sp-2] = t;
                  stack_mem[stack_sp-1] = u;
               end
               OP_NROT: begin
                  stack_mem[stack_sp-3] = t; stack_mem[stack_sp-2] = u;
                  stack_mem[stack_sp-1] = s;
               end
               OP_ADD: r = s + t;
               OP_SUB: r = s - t;
               OP_MUL: r = s * t;
               OP_DIV: r = signed_divide(s, t, 1'b0);
               OP_MOD: r = signed_divide(s, t, 1'b1);
               OP_EQ: r = 64'(s == t);
               OP_NE: r = 64'(s != t);
               OP_LT: r = 64'($signed(s) < $signed(t));
               OP_GT: r = 64'($signed(s) > $signed(t));
               OP_LE: r = 64'($signed(s) <= $signed(t));
               OP_GE: r = 64'($signed(s) >= $signed(t));
               OP_LAND: r = 64'(s != 0 && t != 0);
               OP_LOR: r = 64'(s != 0 || t != 0);
               OP_LNOT: stack_mem[stack_sp-1] = 64'(t == 0);
               OP_BAND: r = s & t;
               OP_BOR: r = s | t;
               OP_BXOR: r = s ^ t;
               OP_BNOT: stack_mem[stack_sp-1] = ~t;
               OP_STORE: begin data_mem[wi] = s; stack_sp -= 2; end
               OP_FETCH: stack_mem[stack_sp-1] = data_mem[wi];
               OP_ADDST: begin data_mem[wi] = data_mem[wi] + s; stack_sp -= 2; end
               OP_SUBST: begin data_mem[wi] = data_mem[wi] - s; stack_sp -= 2; end
               OP_CSTORE: begin data_mem[wi][sh +: 8] = s[7:0]; stack_sp -= 2; end
               default: begin
                  b = 64'($signed(data_mem[wi][sh +: 8]));
                  stack_mem[stack_sp-1] = b;
               end
            endcase
            if (binary) begin
               stack_mem[stack_sp-2] = r;
               stack_sp--;
            end
         end
      end
      rs.top_value = stack_sp != 0 ? stack_mem[stack_sp-1] : '0;
      rs.depth_now = 6'(stack_sp);
      rs.branch_taken = taken;
      rs.status = st;
      expected_rsp_q.push_back(rs);
   endfunction

   // Valid stays high after the beat; the next call either lowers it for a
   // gap or replaces the payload at once.
   task automatic send_primitive(input logic [5:0] op, input logic [63:0] value = '0);
      req_type rq;
      int gap;
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      rq.action = op;
      rq.operand = value;
      req_valid <= 1'b1;
      req_data <= rq;
      do @(posedge clock); while (!req_ready);
      execute_primitive(rq);
   endtask

   function automatic logic [63:0] random_word();
      case ($urandom_range(0, 5))
         0: return 64'h8000_0000_0000_0000;
         1: return 64'h7fff_ffff_ffff_ffff;
         2: return 64'(int'($urandom_range(0, 8)) - 4);
         3: return 64'($urandom_range(0, 2047));
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic test_directed();
      send_primitive(OP_DROP);
      send_primitive(OP_BR, 64'd5);
      send_primitive(OP_LIT, 64'h8000_0000_0000_0000);
      send_primitive(OP_LIT, 64'hffff_ffff_ffff_ffff);
      send_primitive(OP_DIV);
      send_primitive(OP_LIT, 64'h8000_0000_0000_0000);
      send_primitive(OP_LIT, 64'hffff_ffff_ffff_ffff);
      send_primitive(OP_MOD);
      send_primitive(OP_LIT, 64'd0);
      send_primitive(OP_DIV);
      send_primitive(OP_ZBR);
      send_primitive(OP_ROT);
      send_primitive(6'd33);
      send_primitive(6'd63);
      send_primitive(OP_LIT, 64'h7fff_ffff_ffff_ffff);
      send_primitive(OP_LIT, 64'd1);
      send_primitive(OP_ADD);
      send_primitive(OP_LIT, 64'd2047);
      send_primitive(OP_CSTORE);
      send_primitive(OP_LIT, 64'd2047);
      send_primitive(OP_CFETCH);
      send_primitive(OP_DROP);
      send_primitive(OP_DROP);
   endtask

   // Fill past the top to hit overflow, then drain to empty.
   task automatic test_stack_limits();
      repeat (Depth + 2) send_primitive(OP_LIT, random_word());
      send_primitive(OP_DUP);
      send_primitive(OP_OVER);
      repeat (Depth + 1) send_primitive(OP_DROP);
   endtask

   task automatic test_random_programs();
      logic [5:0] op;
      for (int i = 0; i < 650; i++) begin
         // Keep a few operands around so most primitives get past the checks.
         if (stack_sp < 3 && $urandom_range(0, 3) != 0) op = OP_LIT;
         else if ($urandom_range(0, 19) == 0) op = 6'($urandom_range(33, 63));
         else if ($urandom_range(0, 3) == 0) op = OP_LIT;
         else op = 6'($urandom_range(0, 32));
         send_primitive(op, random_word());
      end
   endtask

   // Responses are held off while requests keep coming, so the block backs up.
   task automatic test_backpressure();
      hold_off = 1'b1;
      fork
         begin
            repeat (300) @(posedge clock);
            hold_off = 1'b0;
         end
         repeat (8) send_primitive(OP_LIT, random_word());
      join
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp_q.size() == 0) begin
               $error("unexpected response beat");
               error_count++;
            end else begin
               rsp_type e;
               e = expected_rsp_q.pop_front();
               if (rsp_data.top_value !== e.top_value) begin
                  $error("top_value expected %h actual %h", e.top_value, rsp_data.top_value);
                  error_count++;
               end
               if (rsp_data.depth_now !== e.depth_now) begin
                  $error("depth_now expected %0d actual %0d", e.depth_now, rsp_data.depth_now);
                  error_count++;
               end
               if (rsp_data.branch_taken !== e.branch_taken) begin
                  $error("branch_taken expected %b actual %b", e.branch_taken,
                         rsp_data.branch_taken);
                  error_count++;
               end
               if (rsp_data.status !== e.status) begin
                  $error("status expected %0d actual %0d", e.status, rsp_data.status);
                  error_count++;
               end
            end
         end
      end
   end

   // Receiver draws a stall length per beat; ready is lowered only when it
   // actually stalls.
   initial begin
      int wait_cycles;
      forever begin
         wait_cycles = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 11);
         if (wait_cycles != 0 || hold_off) begin
            rsp_ready <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
            while (hold_off) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      stack_sp = 0;
      foreach (data_mem[i]) data_mem[i] = '0;
      foreach (stack_mem[i]) stack_mem[i] = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_stack_limits();
      test_backpressure();
      test_random_programs();
      req_valid <= 1'b0;
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
